// ===== rtl/tksd_pkg.sv =====
`timescale 1ns / 1ps

package tksd_pkg;

    // Key event codes
    typedef enum logic [2:0] {
        KIND_NONE      = 3'd0,
        KIND_ESCAPE    = 3'd1,
        KIND_ENTER     = 3'd2,
        KIND_NEWLINE   = 3'd3,
        KIND_CTRL_C    = 3'd4,
        KIND_CTRL_Q    = 3'd5,
        KIND_BACKSPACE = 3'd6,
        KIND_CHAR      = 3'd7
    } t_key_kind;

    // Default sequence length limit, ESC included
    localparam int DEFAULT_MAX_SEQ_LEN = 32;

    // Byte codes
    localparam logic [7:0] BYTE_ESC       = 8'h1b;
    localparam logic [7:0] BYTE_CR        = 8'h0d;
    localparam logic [7:0] BYTE_LF        = 8'h0a;
    localparam logic [7:0] BYTE_CTRL_C    = 8'h03;
    localparam logic [7:0] BYTE_CTRL_Q    = 8'h11;
    localparam logic [7:0] BYTE_DEL       = 8'h7f;
    localparam logic [7:0] BYTE_SPACE     = 8'h20;
    localparam logic [7:0] BYTE_TILDE     = 8'h7e;
    localparam logic [7:0] BYTE_FINAL_LO  = 8'h40;
    localparam logic [7:0] BYTE_FINAL_HI  = 8'h7e;
    localparam logic [7:0] BYTE_LBRACKET  = 8'h5b;
    localparam logic [7:0] BYTE_SEMI      = 8'h3b;
    localparam logic [7:0] BYTE_DIGIT_0   = 8'h30;
    localparam logic [7:0] BYTE_DIGIT_9   = 8'h39;
    localparam logic [7:0] BYTE_FINAL_U   = 8'h75;

    // CSI parameter values of interest
    localparam logic [15:0] PARAM_CR      = 16'd13;
    localparam logic [15:0] PARAM_J       = 16'd106;
    localparam logic [15:0] PARAM_C       = 16'd99;
    localparam logic [15:0] PARAM_Q       = 16'd113;
    localparam logic [15:0] PARAM_ESC     = 16'd27;
    localparam logic [15:0] MOD_SHIFT     = 16'd2;
    localparam logic [15:0] MOD_ALT       = 16'd3;
    localparam logic [15:0] MOD_CTRL      = 16'd5;
    localparam logic [15:0] PARAM_SAT     = 16'hffff;

    localparam int NUM_PARAMS = 3;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] data_byte;
        logic       burst_end;
    } t_key_item;

    typedef struct packed {
        t_key_kind  key_kind;
        logic [6:0] char_code;
    } t_key_result;

    // Control from the pipeline shell to the decoder core
    typedef struct packed {
        logic item_valid;
        logic advance;
    } t_step_ctl;

    // Status from the decoder core
    typedef struct packed {
        logic        has_result;
        t_key_result result;
    } t_step_sts;

endpackage

// ===== rtl/tksd_in_if.sv =====
`timescale 1ns / 1ps

interface tksd_in_if;
    logic       valid;
    logic       ready;
    logic       has_byte;
    logic [7:0] data_byte;
    logic       burst_end;

    modport source (output valid, output has_byte, output data_byte, output burst_end,
                    input ready);
    modport sink   (input valid, input has_byte, input data_byte, input burst_end,
                    output ready);
endinterface

// ===== rtl/tksd_out_if.sv =====
`timescale 1ns / 1ps

interface tksd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] key_kind;
    logic [6:0] char_code;

    modport source (output valid, output key_kind, output char_code, input ready);
    modport sink   (input valid, input key_kind, input char_code, output ready);
endinterface

// ===== rtl/tksd_seq_core.sv =====
`timescale 1ns / 1ps

module tksd_seq_core #(
    parameter int MAX_SEQ_LEN = tksd_pkg::DEFAULT_MAX_SEQ_LEN
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tksd_pkg::t_step_ctl i_ctl,
    input  tksd_pkg::t_key_item i_item,
    output tksd_pkg::t_step_sts o_sts
);
    import tksd_pkg::*;

    localparam int LEN_W = $clog2(MAX_SEQ_LEN + 1);

    // Sequence state
    logic                       r_in_seq,  n_in_seq;
    logic [LEN_W-1:0]           r_len,     n_len;
    logic                       r_csi,     n_csi;
    logic                       r_cr,      n_cr;
    logic                       r_err,     n_err;
    logic [NUM_PARAMS-1:0][15:0] r_pval,   n_pval;
    logic [NUM_PARAMS-1:0]      r_pset,    n_pset;
    logic [1:0]                 r_slot,    n_slot;

    logic        w_res;
    t_key_kind   w_kind;
    logic [6:0]  w_char;

    function automatic logic is_final(input logic [7:0] b);
        is_final = (b >= BYTE_FINAL_LO) && (b <= BYTE_FINAL_HI);
    endfunction

    // Decode a closed sequence from its updated state
    function automatic t_key_kind decode_seq(
        input logic [LEN_W-1:0]            len,
        input logic                        csi,
        input logic                        cr,
        input logic                        err,
        input logic                        has_final,
        input logic [7:0]                  fin,
        input logic [NUM_PARAMS-1:0][15:0] pv,
        input logic [NUM_PARAMS-1:0]       ps
    );
        logic p0_cr, p0_j, p0_c, p0_q, p0_esc, p2_cr;
        logic m_shift, m_alt, m_ctrl;
        t_key_kind k;
        p0_cr   = ps[0] && (pv[0] == PARAM_CR);
        p0_j    = ps[0] && (pv[0] == PARAM_J);
        p0_c    = ps[0] && (pv[0] == PARAM_C);
        p0_q    = ps[0] && (pv[0] == PARAM_Q);
        p0_esc  = ps[0] && (pv[0] == PARAM_ESC);
        p2_cr   = ps[2] && (pv[2] == PARAM_CR);
        // absent or zero modifier means 1, which matches none of these
        m_shift = ps[1] && (pv[1] == MOD_SHIFT);
        m_alt   = ps[1] && (pv[1] == MOD_ALT);
        m_ctrl  = ps[1] && (pv[1] == MOD_CTRL);
        k = KIND_NONE;
        if (len == LEN_W'(1)) begin
            k = KIND_ESCAPE;
        end else if (len == LEN_W'(2) && cr) begin
            k = KIND_NEWLINE;
        end else if (!csi || len < LEN_W'(3) || err || !has_final) begin
            k = KIND_NONE;
        end else if (fin == BYTE_FINAL_U) begin
            if ((p0_cr && (m_shift || m_alt || m_ctrl)) || (p0_j && m_ctrl)) begin
                k = KIND_NEWLINE;
            end else if (p0_c && m_ctrl) begin
                k = KIND_CTRL_C;
            end else if (p0_q && m_ctrl) begin
                k = KIND_CTRL_Q;
            end
        end else if (fin == BYTE_TILDE) begin
            if (p0_esc && p2_cr && (m_shift || m_ctrl)) begin
                k = KIND_NEWLINE;
            end
        end
        decode_seq = k;
    endfunction

    // Next state and result for the item in the input register
    always_comb begin
        logic [7:0]  b;
        logic        fin_ok;
        logic [19:0] acc;
        b        = i_item.data_byte;
        fin_ok   = 1'b0;
        acc      = '0;
        n_in_seq = r_in_seq;
        n_len    = r_len;
        n_csi    = r_csi;
        n_cr     = r_cr;
        n_err    = r_err;
        n_pval   = r_pval;
        n_pset   = r_pset;
        n_slot   = r_slot;
        w_res    = 1'b0;
        w_kind   = KIND_NONE;
        w_char   = '0;

        if (!i_item.has_byte) begin
            // tick: close an open sequence on burst end
            if (r_in_seq && i_item.burst_end) begin
                w_res    = 1'b1;
                w_kind   = decode_seq(r_len, r_csi, r_cr, r_err, 1'b0, '0, r_pval, r_pset);
                n_in_seq = 1'b0;
                n_len    = '0;
            end
        end else if (!r_in_seq) begin
            if (b == BYTE_ESC) begin
                // open a sequence, or report a lone escape at once
                n_in_seq = 1'b1;
                n_len    = LEN_W'(1);
                n_csi    = 1'b0;
                n_cr     = 1'b0;
                n_err    = 1'b0;
                n_pval   = '0;
                n_pset   = '0;
                n_slot   = '0;
                if (i_item.burst_end) begin
                    w_res    = 1'b1;
                    w_kind   = KIND_ESCAPE;
                    n_in_seq = 1'b0;
                    n_len    = '0;
                end
            end else begin
                // classify a single byte
                w_res = 1'b1;
                if (b == BYTE_CR) begin
                    w_kind = KIND_ENTER;
                end else if (b == BYTE_LF) begin
                    w_kind = KIND_NEWLINE;
                end else if (b == BYTE_CTRL_C) begin
                    w_kind = KIND_CTRL_C;
                end else if (b == BYTE_CTRL_Q) begin
                    w_kind = KIND_CTRL_Q;
                end else if (b == BYTE_DEL) begin
                    w_kind = KIND_BACKSPACE;
                end else if (b >= BYTE_SPACE && b <= BYTE_TILDE) begin
                    w_kind = KIND_CHAR;
                    w_char = b[6:0];
                end
            end
        end else begin
            // byte inside an open sequence
            n_len = r_len + LEN_W'(1);
            if (r_len == LEN_W'(1)) begin
                if (b == BYTE_LBRACKET) begin
                    n_csi = 1'b1;
                end else if (b == BYTE_CR) begin
                    n_cr = 1'b1;
                end
                fin_ok = (b != BYTE_LBRACKET) && is_final(b);
            end else begin
                if (r_csi) begin
                    if (b >= BYTE_DIGIT_0 && b <= BYTE_DIGIT_9) begin
                        for (int i = 0; i < NUM_PARAMS; i++) begin
                            if (r_slot == 2'(i)) begin
                                acc = ({4'b0, r_pval[i]} << 3) + ({4'b0, r_pval[i]} << 1)
                                    + {16'b0, b[3:0]};
                                n_pval[i] = (acc > {4'b0, PARAM_SAT}) ? PARAM_SAT : acc[15:0];
                                n_pset[i] = 1'b1;
                            end
                        end
                    end else if (b == BYTE_SEMI) begin
                        if (r_slot < 2'(NUM_PARAMS - 1)) begin
                            n_slot = r_slot + 2'd1;
                        end
                    end else if (!is_final(b)) begin
                        n_err = 1'b1;
                    end
                end
                fin_ok = is_final(b);
            end
            if (fin_ok || i_item.burst_end || n_len >= LEN_W'(MAX_SEQ_LEN)) begin
                w_res    = 1'b1;
                w_kind   = decode_seq(n_len, n_csi, n_cr, n_err, fin_ok, b, n_pval, n_pset);
                n_in_seq = 1'b0;
                n_len    = '0;
            end
        end
    end

    assign o_sts.has_result       = i_ctl.item_valid && w_res;
    assign o_sts.result.key_kind  = w_kind;
    assign o_sts.result.char_code = w_char;

    // Advance state when the item leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_seq <= 1'b0;
            r_len    <= '0;
            r_csi    <= 1'b0;
            r_cr     <= 1'b0;
            r_err    <= 1'b0;
            r_pval   <= '0;
            r_pset   <= '0;
            r_slot   <= '0;
        end else if (i_ctl.advance) begin
            r_in_seq <= n_in_seq;
            r_len    <= n_len;
            r_csi    <= n_csi;
            r_cr     <= n_cr;
            r_err    <= n_err;
            r_pval   <= n_pval;
            r_pset   <= n_pset;
            r_slot   <= n_slot;
        end
    end

endmodule

// ===== rtl/terminal_key_sequence_decoder_unit.sv =====
`timescale 1ns / 1ps
// Path: an accepted beat is held in the input register, and its key event moves on to the
// result register once the output side is free.
// Throughput: one beat per cycle unless a result is blocked; the decode is combinational.
// Reset: synchronous active-low i_rst_n closes any open sequence and empties both registers.

module terminal_key_sequence_decoder_unit #(
    parameter int MAX_SEQ_LEN = tksd_pkg::DEFAULT_MAX_SEQ_LEN
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tksd_in_if.sink    i_key_in,
    tksd_out_if.source o_key_out
);
    import tksd_pkg::*;

    logic        r_in_valid;
    t_key_item   r_in;
    logic        r_out_valid;
    t_key_result r_out;

    t_step_ctl   w_ctl;
    t_step_sts   w_sts;
    logic        w_out_free;
    logic        w_advance;
    logic        w_in_ready;

    // Move the held beat on unless its result has nowhere to go
    assign w_out_free = !r_out_valid || o_key_out.ready;
    assign w_advance  = r_in_valid && (!w_sts.has_result || w_out_free);
    assign w_in_ready = !r_in_valid || w_advance;

    assign w_ctl.item_valid = r_in_valid;
    assign w_ctl.advance    = w_advance;

    tksd_seq_core #(
        .MAX_SEQ_LEN (MAX_SEQ_LEN)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_item  (r_in),
        .o_sts   (w_sts)
    );

    // Capture input beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_key_in.valid && w_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_key_in.valid && w_in_ready) begin
            r_in.has_byte  <= i_key_in.has_byte;
            r_in.data_byte <= i_key_in.data_byte;
            r_in.burst_end <= i_key_in.burst_end;
        end
    end

    // Hold results until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_sts.has_result) begin
            r_out_valid <= 1'b1;
        end else if (o_key_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_sts.has_result) begin
            r_out <= w_sts.result;
        end
    end

    assign i_key_in.ready      = w_in_ready;
    assign o_key_out.valid     = r_out_valid;
    assign o_key_out.key_kind  = r_out.key_kind;
    assign o_key_out.char_code = r_out.char_code;

endmodule

// ===== rtl/tksd_checker.sv =====
`timescale 1ns / 1ps

module tksd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_key_kind,
    input logic [6:0] i_char_code
);
    import tksd_pkg::*;

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_key_kind) && $stable(i_char_code))
        else $error("result beat changed while stalled");

    // Input backpressure only comes from a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled while result side is free");

    // Character code only rides with a character event
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_key_kind != KIND_CHAR) |-> i_char_code == 7'd0)
        else $error("character code set on a non-character event");

    // Character events carry a printable code
    a_char_print: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_key_kind == KIND_CHAR) |->
            (i_char_code >= BYTE_SPACE[6:0]) && (i_char_code <= BYTE_TILDE[6:0]))
        else $error("character event outside printable range");

endmodule

bind terminal_key_sequence_decoder_unit tksd_checker u_tksd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_key_in.ready),
    .i_out_valid (o_key_out.valid),
    .i_out_ready (o_key_out.ready),
    .i_key_kind  (o_key_out.key_kind),
    .i_char_code (o_key_out.char_code)
);
